FILE: design/fps_pkg.sv
// fps_pkg: shared types and constants of the farthest point sampler
// opcodes, status codes, register indexes and controller/datapath structs
// no dependencies
package fps_pkg;

  localparam int DEF_MAX_POINTS  = 4096;
  localparam int DEF_MAX_DIMS    = 3;
  localparam int DEF_COORD_WIDTH = 16;

  localparam int INDEX_OUT_W = 12;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CFG_INDEX_W-1:0] CFG_START_INDEX = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DIMS_USED   = 2'd1;

  localparam logic [11:0] START_INDEX_RESET = 12'd0;
  localparam logic [1:0]  DIMS_USED_RESET   = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NONE   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BEYOND = 2'd3
  } status_e;

  typedef struct packed {
    logic load;
    logic clear;
    logic emit;
    logic start;
    logic latch;
    logic issue;
  } fps_cmd_t;

  typedef struct packed {
    status_e req_status;
    logic    last;
    logic    pipe_busy;
  } fps_stat_t;

endpackage

FILE: design/farthest_point_sampler.sv
// farthest point sampler: load and clear words act on acceptance
// a sample request gives its result word the cycle after acceptance; an ok request
// then sweeps all loaded points and is busy until the sweep drains, an
// erroring request needs no sweep; one point per cycle through the shared read port
// reset is asynchronous active low and clears control state only; no clearing
// pass, the point count keeps unwritten ram entries from being read
module farthest_point_sampler import fps_pkg::*; #(
  parameter int MAX_POINTS  = DEF_MAX_POINTS,
  parameter int MAX_DIMS    = DEF_MAX_DIMS,
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    opcode_i,
  input  logic signed [COORD_WIDTH-1:0] coord_x_i,
  input  logic signed [COORD_WIDTH-1:0] coord_y_i,
  input  logic signed [COORD_WIDTH-1:0] coord_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [INDEX_OUT_W-1:0]        sample_index_o,
  output logic [INDEX_OUT_W-1:0]        sample_number_o,
  output logic [1:0]                    status_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i
);

  fps_cmd_t  cmd;
  fps_stat_t stat;

  assign cfg_ready_o = 1'b1;

  fps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fps_datapath #(
    .MAX_POINTS  (MAX_POINTS),
    .MAX_DIMS    (MAX_DIMS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .coord_x_i       (coord_x_i),
    .coord_y_i       (coord_y_i),
    .coord_z_i       (coord_z_i),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .sample_index_o  (sample_index_o),
    .sample_number_o (sample_number_o),
    .status_o        (status_o)
  );

endmodule

FILE: design/fps_ram.sv
// fps_ram: generic single write port, single read port ram
// registered read data; no dependencies
module fps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/fps_ctrl.sv
// fps_ctrl: sequencer of the farthest point sampler
// handshakes, output word valid and sweep sequencing; uses fps_pkg
module fps_ctrl import fps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic [1:0] opcode_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  fps_stat_t stat_i,
  output fps_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_SWEEP,
    S_DRAIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   is_load, is_sample, is_clear;

  always_comb begin
    is_load   = 1'b0;
    is_sample = 1'b0;
    is_clear  = 1'b0;
    case (opcode_e'(opcode_i))
      OP_LOAD:   is_load   = 1'b1;
      OP_SAMPLE: is_sample = 1'b1;
      OP_CLEAR:  is_clear  = 1'b1;
      default:   ;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE) && (!is_sample || !out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o       = '0;
    cmd_o.load  = accept && is_load;
    cmd_o.clear = accept && is_clear;
    cmd_o.emit  = accept && is_sample;
    cmd_o.start = accept && is_sample && (stat_i.req_status == ST_OK);
    cmd_o.latch = (state_q == S_FETCH);
    cmd_o.issue = (state_q == S_SWEEP);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (cmd_o.start) state_d = S_FETCH;
      S_FETCH: state_d = S_SWEEP;
      S_SWEEP: if (stat_i.last) state_d = S_DRAIN;
      S_DRAIN: if (!stat_i.pipe_busy) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: design/fps_datapath.sv
// fps_datapath: point store, running minima, distance pipeline and argmax
// configuration registers and result word; uses fps_pkg and fps_ram
module fps_datapath import fps_pkg::*; #(
  parameter int MAX_POINTS  = DEF_MAX_POINTS,
  parameter int MAX_DIMS    = DEF_MAX_DIMS,
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [COORD_WIDTH-1:0] coord_x_i,
  input  logic [COORD_WIDTH-1:0] coord_y_i,
  input  logic [COORD_WIDTH-1:0] coord_z_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  fps_cmd_t               cmd_i,
  output fps_stat_t              stat_o,
  output logic [INDEX_OUT_W-1:0] sample_index_o,
  output logic [INDEX_OUT_W-1:0] sample_number_o,
  output logic [1:0]             status_o
);

  localparam int CW     = COORD_WIDTH;
  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int EXT_W  = (CNT_W > INDEX_OUT_W) ? CNT_W : INDEX_OUT_W;
  localparam int DIST_W = 2 * CW + 2;
  localparam int SQ_W   = 2 * CW + 1;
  localparam int PT_W   = MAX_DIMS * CW;
  localparam logic [DIST_W-1:0] DIST_ONES = '1;

  logic [11:0]      start_q;
  logic [1:0]       dims_q;
  logic [1:0]       dims_eff;

  logic [CNT_W-1:0] loaded_q, done_q;
  logic [IDX_W-1:0] next_pick_q;
  logic [DIST_W-1:0] best_q;
  logic             found_q;
  logic [IDX_W-1:0] cur_pick_q;
  logic [CW-1:0]    pc_q [MAX_DIMS];
  logic [IDX_W-1:0] cnt_q;

  logic             full, load_ok;
  status_e          req_status;
  logic [IDX_W-1:0] pick_sel;
  logic [EXT_W-1:0] start_ext, loaded_ext, pick_ext, done_ext;

  logic [CW-1:0]    coord_in [3];
  logic [PT_W-1:0]  pt_wdata, pt_rdata;
  logic [CW-1:0]    pt_rd [MAX_DIMS];
  logic [DIST_W:0]  md_wdata, md_rdata;
  logic             md_we;
  logic [IDX_W-1:0] md_waddr, raddr;

  logic             v1_q, v2_q, v3_q, v4_q;
  logic [IDX_W-1:0] idx1_q, idx2_q, idx3_q, idx4_q;
  logic signed [CW:0]     diff [MAX_DIMS];
  logic signed [2*CW+1:0] prod [MAX_DIMS];
  logic [SQ_W-1:0]  sq_q [MAX_DIMS];
  logic [DIST_W-1:0] dist2_q, dist3_q, sum3_q, sum2, min4_q, new_min;
  logic             tk2_q, tk3_q, tk4_q;

  logic [INDEX_OUT_W-1:0] sidx_q, snum_q;
  status_e          status_q;

  assign coord_in[0] = coord_x_i;
  assign coord_in[1] = coord_y_i;
  assign coord_in[2] = coord_z_i;

  always_comb begin
    dims_eff = dims_q;
    if (dims_q == 2'd0) begin
      dims_eff = 2'd1;
    end else if (dims_q > 2'(MAX_DIMS)) begin
      dims_eff = 2'(MAX_DIMS);
    end
  end

  assign full    = (loaded_q == CNT_W'(MAX_POINTS));
  assign load_ok = cmd_i.load && !full;

  // request decision
  assign start_ext  = EXT_W'(start_q);
  assign loaded_ext = EXT_W'(loaded_q);
  always_comb begin
    req_status = ST_OK;
    pick_sel   = '0;
    if (loaded_q == '0) begin
      req_status = ST_EMPTY;
    end else if (done_q == '0) begin
      if (start_ext >= loaded_ext) begin
        req_status = ST_BEYOND;
      end else begin
        pick_sel = start_ext[IDX_W-1:0];
      end
    end else if (!found_q) begin
      req_status = ST_NONE;
    end else begin
      pick_sel = next_pick_q;
    end
  end

  assign pick_ext = EXT_W'(pick_sel);
  assign done_ext = EXT_W'(done_q);

  // memories
  always_comb begin
    for (int j = 0; j < MAX_DIMS; j++) begin
      pt_wdata[j*CW +: CW] = coord_in[j];
      pt_rd[j]             = pt_rdata[j*CW +: CW];
    end
  end

  assign raddr = cmd_i.issue ? cnt_q : pick_sel;

  fps_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (load_ok),
    .waddr_i (loaded_q[IDX_W-1:0]),
    .wdata_i (pt_wdata),
    .raddr_i (raddr),
    .rdata_o (pt_rdata)
  );

  always_comb begin
    new_min = (sum3_q < dist3_q) ? sum3_q : dist3_q;
    if (v3_q) begin
      md_we    = !tk3_q;
      md_waddr = idx3_q;
      md_wdata = {(idx3_q == cur_pick_q), new_min};
    end else begin
      md_we    = load_ok;
      md_waddr = loaded_q[IDX_W-1:0];
      md_wdata = {1'b0, DIST_ONES};
    end
  end

  fps_ram #(.WIDTH(DIST_W + 1), .DEPTH(MAX_POINTS)) u_mindist_ram (
    .clk_i   (clk_i),
    .we_i    (md_we),
    .waddr_i (md_waddr),
    .wdata_i (md_wdata),
    .raddr_i (raddr),
    .rdata_o (md_rdata)
  );

  // distance pipeline
  always_comb begin
    for (int j = 0; j < MAX_DIMS; j++) begin
      diff[j] = $signed({pt_rd[j][CW-1], pt_rd[j]}) - $signed({pc_q[j][CW-1], pc_q[j]});
      prod[j] = diff[j] * diff[j];
    end
    sum2 = '0;
    for (int j = 0; j < MAX_DIMS; j++) begin
      if (2'(j) < dims_eff) begin
        sum2 = sum2 + DIST_W'(sq_q[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q  <= cnt_q;
    for (int j = 0; j < MAX_DIMS; j++) begin
      sq_q[j] <= prod[j][SQ_W-1:0];
    end
    dist2_q <= md_rdata[DIST_W-1:0];
    tk2_q   <= md_rdata[DIST_W];
    idx2_q  <= idx1_q;
    sum3_q  <= sum2;
    dist3_q <= dist2_q;
    tk3_q   <= tk2_q;
    idx3_q  <= idx2_q;
    min4_q  <= tk3_q ? dist3_q : new_min;
    tk4_q   <= tk3_q || (idx3_q == cur_pick_q);
    idx4_q  <= idx3_q;
    if (cmd_i.start) begin
      cur_pick_q <= pick_sel;
    end
    if (cmd_i.latch) begin
      for (int j = 0; j < MAX_DIMS; j++) begin
        pc_q[j] <= pt_rd[j];
      end
    end
    if (cmd_i.emit) begin
      sidx_q   <= pick_ext[INDEX_OUT_W-1:0];
      snum_q   <= done_ext[INDEX_OUT_W-1:0];
      status_q <= req_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= START_INDEX_RESET;
      dims_q      <= DIMS_USED_RESET;
      loaded_q    <= '0;
      done_q      <= '0;
      next_pick_q <= '0;
      best_q      <= '0;
      found_q     <= 1'b0;
      cnt_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_START_INDEX: start_q <= cfg_data_i[11:0];
          CFG_DIMS_USED:   dims_q  <= cfg_data_i[1:0];
          default:         ;
        endcase
      end
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      if (cmd_i.issue) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.clear) begin
        loaded_q <= '0;
        done_q   <= '0;
        best_q   <= '0;
        found_q  <= 1'b0;
      end else if (load_ok) begin
        loaded_q <= loaded_q + 1'b1;
        // a fresh point carries the maximum distance
        if (!found_q || best_q != DIST_ONES) begin
          next_pick_q <= loaded_q[IDX_W-1:0];
          best_q      <= DIST_ONES;
          found_q     <= 1'b1;
        end
      end else if (cmd_i.start) begin
        done_q  <= done_q + 1'b1;
        cnt_q   <= '0;
        best_q  <= '0;
        found_q <= 1'b0;
      end else if (v4_q && !tk4_q && (min4_q > best_q)) begin
        next_pick_q <= idx4_q;
        best_q      <= min4_q;
        found_q     <= 1'b1;
      end
    end
  end

  assign stat_o.req_status = req_status;
  assign stat_o.last       = ({1'b0, cnt_q} == (loaded_q - 1'b1));
  assign stat_o.pipe_busy  = v1_q || v2_q || v3_q || v4_q;

  assign sample_index_o  = sidx_q;
  assign sample_number_o = snum_q;
  assign status_o        = status_q;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// testbench for farthest_point_sampler: a scoreboard class tracks the point cloud
// and predicts each sample word; plain tasks drive words and register writes
// depends on fps_pkg and the farthest_point_sampler rtl
module testbench;
  import fps_pkg::*;

  localparam int MAX_PTS     = DEF_MAX_POINTS;
  localparam int COORD_W     = DEF_COORD_WIDTH;
  localparam int DIST_W      = 2 * COORD_W + 2;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 100;
  localparam int PHASES      = 5;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_B = 2'd3;
  localparam logic [7:0] STALL_PATTERN = 8'b1011_0010;

  typedef struct packed {
    logic [INDEX_OUT_W-1:0] index;
    logic [INDEX_OUT_W-1:0] number;
    status_e                status;
  } sample_t;

  class sample_scoreboard;
    logic signed [COORD_W-1:0] px [MAX_PTS];
    logic signed [COORD_W-1:0] py [MAX_PTS];
    logic signed [COORD_W-1:0] pz [MAX_PTS];
    logic [DIST_W-1:0]         nearest [MAX_PTS];
    bit                        taken [MAX_PTS];
    int                        loaded;
    int                        done;
    logic [11:0]               start_index;
    logic [1:0]                dims_used;
    sample_t                   awaited_samples [$];
    int                        mismatches;

    function new();
      loaded      = 0;
      done        = 0;
      start_index = START_INDEX_RESET;
      dims_used   = DIMS_USED_RESET;
      mismatches  = 0;
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_START_INDEX) begin
        start_index = data[11:0];
      end else if (idx == CFG_DIMS_USED) begin
        dims_used = data[1:0];
      end
    endfunction

    function logic [DIST_W-1:0] squared_gap(int a, int b);
      longint d;
      longint sum;
      int     dims;
      dims = (dims_used == 2'd0) ? 1 : int'(dims_used);
      d = longint'(px[a]) - longint'(px[b]);
      sum = d * d;
      if (dims > 1) begin
        d = longint'(py[a]) - longint'(py[b]);
        sum += d * d;
      end
      if (dims > 2) begin
        d = longint'(pz[a]) - longint'(pz[b]);
        sum += d * d;
      end
      return sum[DIST_W-1:0];
    endfunction

    function void apply_word(logic [1:0] op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [COORD_W-1:0] z);
      sample_t           exp_s;
      logic [DIST_W-1:0] best;
      logic [DIST_W-1:0] d;
      int                pick;
      bit                found;
      case (op)
        OP_LOAD: begin
          if (loaded < MAX_PTS) begin
            px[loaded]      = x;
            py[loaded]      = y;
            pz[loaded]      = z;
            nearest[loaded] = '1;
            taken[loaded]   = 1'b0;
            loaded++;
          end
        end
        OP_CLEAR: begin
          loaded = 0;
          done   = 0;
        end
        OP_SAMPLE: begin
          exp_s.index  = '0;
          exp_s.number = 12'(done);
          exp_s.status = ST_OK;
          pick = 0;
          if (loaded == 0) begin
            exp_s.status = ST_EMPTY;
          end else if (done == 0) begin
            if (int'(start_index) >= loaded) exp_s.status = ST_BEYOND;
            else pick = int'(start_index);
          end else begin
            best  = '0;
            found = 1'b0;
            for (int i = 0; i < loaded; i++) begin
              if (!taken[i] && nearest[i] > best) begin
                best  = nearest[i];
                pick  = i;
                found = 1'b1;
              end
            end
            if (!found) exp_s.status = ST_NONE;
          end
          if (exp_s.status == ST_OK) begin
            exp_s.index = 12'(pick);
            for (int i = 0; i < loaded; i++) begin
              if (!taken[i]) begin
                d = squared_gap(pick, i);
                if (d < nearest[i]) nearest[i] = d;
              end
            end
            taken[pick] = 1'b1;
            done++;
          end
          awaited_samples.push_back(exp_s);
        end
        default: ;
      endcase
    endfunction

    function void check_sample(logic [INDEX_OUT_W-1:0] idx, logic [INDEX_OUT_W-1:0] num,
                               logic [1:0] st);
      sample_t exp_s;
      if (awaited_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected sample word: index %0d number %0d status %0d", idx, num, st);
        return;
      end
      exp_s = awaited_samples.pop_front();
      if (idx !== exp_s.index || num !== exp_s.number || st !== exp_s.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("sample %0d: expected index %0d status %0d, got index %0d number %0d status %0d",
                   exp_s.number, exp_s.index, exp_s.status, idx, num, st);
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [1:0]             opcode_i;
  logic [COORD_W-1:0]     coord_x_i;
  logic [COORD_W-1:0]     coord_y_i;
  logic [COORD_W-1:0]     coord_z_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [INDEX_OUT_W-1:0] sample_index_o;
  logic [INDEX_OUT_W-1:0] sample_number_o;
  logic [1:0]             status_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  sample_scoreboard sb;
  int               burst_left;
  int               counted_items;
  logic [15:0]      rx_cycle;

  farthest_point_sampler u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .coord_z_i      (coord_z_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_index_o (sample_index_o),
    .sample_number_o(sample_number_o),
    .status_o       (status_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver stalls according to a mode taken from bits 8:7 of a free-running cycle count
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rx_cycle    <= '0;
      out_ready_i <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 16'd1;
      case (rx_cycle[8:7])
        2'd0: out_ready_i <= 1'b1;
        2'd1: out_ready_i <= ($urandom_range(0, 2) != 0);
        2'd2: out_ready_i <= STALL_PATTERN[rx_cycle[2:0]];
        default: out_ready_i <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_sample(sample_index_o, sample_number_o, status_o);
  end

  function automatic logic [COORD_W-1:0] any_coord();
    return COORD_W'($urandom);
  endfunction

  function automatic logic [COORD_W-1:0] styled_coord(int style);
    case (style)
      0: return any_coord();
      1: return COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
    endcase
  endfunction

  task automatic send_word(logic [1:0] op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [COORD_W-1:0] z);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    coord_x_i  <= x;
    coord_y_i  <= y;
    coord_z_i  <= z;
    do @(posedge clk_i); while (!in_ready_o);
    sb.apply_word(op, x, y, z);
    if (op != OP_UNUSED) counted_items++;
    burst_left--;
  endtask

  task automatic do_load(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic [COORD_W-1:0] z);
    send_word(OP_LOAD, x, y, z);
  endtask

  task automatic do_sample();
    send_word(OP_SAMPLE, any_coord(), any_coord(), any_coord());
  endtask

  task automatic do_clear();
    send_word(OP_CLEAR, any_coord(), any_coord(), any_coord());
  endtask

  task automatic load_point(int style);
    do_load(styled_coord(style), styled_coord(style), styled_coord(style));
  endtask

  // sweep after the last sample word may still be running
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.awaited_samples.size() != 0) @(posedge clk_i);
    repeat (sb.loaded + 16) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_register(idx, data);
  endtask

  task automatic configure(logic [11:0] start, logic [CFG_DATA_W-1:0] dims_word, bit spare);
    wait_idle();
    write_reg(CFG_START_INDEX, start);
    write_reg(CFG_DIMS_USED, dims_word);
    if (spare) begin
      write_reg(CFG_UNMAPPED_A, CFG_DATA_W'($urandom));
      write_reg(CFG_UNMAPPED_B, CFG_DATA_W'($urandom));
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_sequence();
    int kind;
    int style;
    int n;
    int k;
    kind  = $urandom_range(0, 9);
    style = $urandom_range(0, 2);
    if (kind <= 7) begin
      do_clear();
      n = $urandom_range(1, 12);
      repeat (n) load_point(style);
      repeat ($urandom_range(1, n + 2)) begin
        k = $urandom_range(0, 19);
        if (k == 0) load_point(style);
        else if (k == 1) send_word(OP_UNUSED, any_coord(), any_coord(), any_coord());
        do_sample();
      end
    end else if (kind == 8) begin
      repeat ($urandom_range(1, 5))
        send_word(2'($urandom_range(0, 3)), any_coord(), any_coord(), any_coord());
    end else begin
      do_clear();
      repeat ($urandom_range(0, 2)) load_point(style);
      repeat ($urandom_range(1, 3)) do_sample();
    end
  endtask

  initial begin
    int random_base;
    sb            = new();
    burst_left    = 0;
    counted_items = 0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    opcode_i      = OP_LOAD;
    coord_x_i     = '0;
    coord_y_i     = '0;
    coord_z_i     = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_START_INDEX;
    cfg_data_i    = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty store, extremes, duplicate point, unused opcode, load after sampling
    do_sample();
    do_load(16'h8000, 16'h8000, 16'h8000);
    do_load(16'h7fff, 16'h7fff, 16'h7fff);
    do_load(16'h0000, 16'h0000, 16'h0000);
    do_load(16'hffff, 16'h0001, 16'h8000);
    do_load(16'h0000, 16'h0000, 16'h0000);
    repeat (5) do_sample();
    send_word(OP_UNUSED, 16'h7fff, 16'h8000, 16'h5555);
    do_load(16'h7fff, 16'h8000, 16'h0001);
    repeat (2) do_sample();
    do_clear();
    do_sample();

    // start index beyond the loaded points, dims word zero
    configure(12'd4095, 12'd0, 1'b0);
    repeat (3) load_point(0);
    repeat (2) do_sample();

    // unmapped register indexes, dims word with upper bits set
    configure(12'd4095, 12'hffe, 1'b1);
    do_clear();
    repeat (12) load_point(0);
    repeat (3) do_sample();

    random_base = counted_items;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: configure(12'($urandom_range(0, 14)), 12'd1, 1'b0);
        1: configure(12'($urandom_range(0, 14)), 12'd2, 1'b0);
        2: configure(12'($urandom_range(0, 14)), 12'd3, 1'b1);
        3: configure(12'd0, 12'd0, 1'b0);
        default: configure(12'($urandom_range(0, 14)), 12'($urandom), 1'b0);
      endcase
      while (counted_items - random_base < (p + 1) * RANDOM_ITEMS / PHASES) run_sequence();
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.awaited_samples.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
design/fps_pkg.sv
design/fps_ram.sv
design/fps_ctrl.sv
design/fps_datapath.sv
design/farthest_point_sampler.sv
tb/testbench.sv
